// ----- hw/rtl/lrt_pkg.sv -----
package lrt_pkg;
    localparam int TableEntries = 16;
    localparam int HopsPerRoute = 4;
    localparam int Interfaces = 16;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP_HOP  = 3'd1;
    localparam logic [2:0] ST_HOP_FULL = 3'd2;
    localparam logic [2:0] ST_TBL_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FND  = 3'd4;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        if (len >= 6'd32) begin
            m = '1;
        end else if (len != 6'd0) begin
            m = ~(32'hFFFF_FFFF >> len);
        end
        return m;
    endfunction
endpackage

// ----- hw/rtl/lpm_route_table_ecmp.sv -----
// Add, lookup and delete scan one table slot per cycle through a single compare
// unit, then decide; a gateway add then reads each stored hop (at most
// HOPS_PER_ROUTE) for a duplicate, a gateway lookup reads the round-robin
// hop, and clear skips the scan. One beat at a time: no new beat until taken.
// Reset (synchronous, active low) clears valid bits, hop counts and
// round-robin pointers; no clearing pass. Output register frees on take.
module lpm_route_table_ecmp #(
    parameter int TABLE_ENTRIES  = lrt_pkg::TableEntries,
    parameter int HOPS_PER_ROUTE = lrt_pkg::HopsPerRoute
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], address[33:2], prefix_len[39:34], has_gateway[40],
    // gateway_ip[72:41], out_interface[76:73], metric[108:77], zero pad
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], found[3], direct[4], hop_gw[36:5],
    // next_hop_interface[40:37], route_metric[72:41], matched_len[78:73], pad
    output logic [79:0]  m_axis_tdata
);
    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HW = (HOPS_PER_ROUTE > 1) ? $clog2(HOPS_PER_ROUTE) : 1;
    localparam int CW = $clog2(HOPS_PER_ROUTE + 1);
    localparam int NW = $clog2(TABLE_ENTRIES + 1);
    localparam int HD = TABLE_ENTRIES * HOPS_PER_ROUTE;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int PW = (lrt_pkg::Interfaces > 1) ? $clog2(lrt_pkg::Interfaces) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_HOPS = 3'd3;
    localparam logic [2:0] S_HRES = 3'd4;
    localparam logic [2:0] S_LRD  = 3'd5;
    localparam logic [2:0] S_LOUT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]      m_prefix [TABLE_ENTRIES];
    logic [5:0]       m_length [TABLE_ENTRIES];
    logic             m_direct [TABLE_ENTRIES];
    logic [31:0]      m_cost   [TABLE_ENTRIES];
    logic [CW-1:0]    r_used   [TABLE_ENTRIES];
    logic [HW-1:0]    r_rr     [TABLE_ENTRIES];
    logic [31:0]      m_hgw    [HD];
    logic [PW-1:0]    m_hport  [HD];

    logic [1:0]  r_mode;
    logic [31:0] r_addr;
    logic [5:0]  r_len;
    logic        r_hasgw;
    logic [31:0] r_gw;
    logic [3:0]  r_port;
    logic [31:0] r_metric;

    logic [NW-1:0] r_idx;
    logic          r_hit;
    logic [EW-1:0] r_hit_idx;
    logic          r_free;
    logic [EW-1:0] r_free_idx;
    logic          r_best;
    logic [EW-1:0] r_best_idx;
    logic [5:0]    r_longest;
    logic          r_dflt;
    logic [EW-1:0] r_dflt_idx;
    logic [EW-1:0] r_e;
    logic [CW-1:0] r_k;
    logic          r_dup;
    logic [31:0]   r_rd_gw;
    logic [PW-1:0] r_rd_port;

    logic [2:0]  r_o_status;
    logic        r_o_found;
    logic        r_o_direct;
    logic [31:0] r_o_nhip;
    logic [3:0]  r_o_nhif;
    logic [31:0] r_o_cost;
    logic [5:0]  r_o_len;

    logic [5:0]    sat_len;
    logic [EW-1:0] cur;
    logic [31:0]   tgt;
    logic          exact;
    logic          lpm_m;
    logic [EW-1:0] n_sel;
    logic [CW-1:0] sel_used;
    logic [HW-1:0] sel_p;
    logic [HW-1:0] n_p;
    logic [HAW-1:0] hop_addr;

    assign sat_len = (s_axis_tdata[39:34] > 6'd32) ? 6'd32 : s_axis_tdata[39:34];
    assign cur = r_idx[EW-1:0];
    assign tgt = r_addr & lrt_pkg::len_mask(r_len);
    assign exact = r_valid[cur] && m_prefix[cur] == tgt && m_length[cur] == r_len;
    assign lpm_m = (r_addr & lrt_pkg::len_mask(m_length[cur])) == m_prefix[cur];
    assign n_sel = r_best ? r_best_idx : r_dflt_idx;
    assign sel_used = r_used[r_e];
    assign sel_p = ({{CW{1'b0}}, r_rr[r_e]} >= {{HW{1'b0}}, sel_used}) ? '0 : r_rr[r_e];
    assign n_p = ((CW'(sel_p) + CW'(1) >= CW'(HOPS_PER_ROUTE)) ||
                  (CW'(sel_p) + CW'(1) >= sel_used)) ? '0 : HW'(sel_p + HW'(1));
    assign hop_addr = (r_state == S_LRD) ? HAW'(r_e * HOPS_PER_ROUTE + sel_p)
                                         : HAW'(r_e * HOPS_PER_ROUTE + r_k[HW-1:0]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {1'b0, r_o_len, r_o_cost, r_o_nhif, r_o_nhip,
                           r_o_direct, r_o_found, r_o_status};

    always_ff @(posedge i_clk) begin
        r_rd_gw <= m_hgw[hop_addr];
        r_rd_port <= m_hport[hop_addr];
        if (r_state == S_DEC && r_mode == lrt_pkg::MODE_ADD && !r_hit && r_free) begin
            m_prefix[r_free_idx] <= tgt;
            m_length[r_free_idx] <= r_len;
            m_direct[r_free_idx] <= 1'b1;
            m_cost[r_free_idx] <= '0;
        end
        if (r_state == S_HRES && !r_dup && r_k < CW'(HOPS_PER_ROUTE)) begin
            m_hgw[hop_addr] <= r_gw;
            m_hport[hop_addr] <= r_port[PW-1:0];
            m_direct[r_e] <= 1'b0;
            m_cost[r_e] <= r_metric;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_used[i] <= '0;
                r_rr[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode <= s_axis_tdata[1:0];
                        r_addr <= s_axis_tdata[33:2];
                        r_len <= sat_len;
                        r_hasgw <= s_axis_tdata[40];
                        r_gw <= s_axis_tdata[72:41];
                        r_port <= s_axis_tdata[76:73];
                        r_metric <= s_axis_tdata[108:77];
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_free <= 1'b0;
                        r_best <= 1'b0;
                        r_dflt <= 1'b0;
                        r_longest <= '0;
                        r_o_status <= lrt_pkg::ST_OK;
                        r_o_found <= 1'b0;
                        r_o_direct <= 1'b0;
                        r_o_nhip <= '0;
                        r_o_nhif <= '0;
                        r_o_cost <= '0;
                        r_o_len <= '0;
                        if (s_axis_tdata[1:0] == lrt_pkg::MODE_CLEAR) begin
                            r_valid <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (exact && !r_hit) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= cur;
                    end
                    if (!r_valid[cur] && !r_free) begin
                        r_free <= 1'b1;
                        r_free_idx <= cur;
                    end
                    if (r_valid[cur]) begin
                        if (m_length[cur] == 6'd0 && m_prefix[cur] == 32'd0) begin
                            r_dflt <= 1'b1;
                            r_dflt_idx <= cur;
                        end else if (lpm_m && m_length[cur] > r_longest) begin
                            r_longest <= m_length[cur];
                            r_best <= 1'b1;
                            r_best_idx <= cur;
                        end
                    end
                    if (r_idx == NW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_DEC;
                    end
                    r_idx <= r_idx + NW'(1);
                end
                S_DEC: begin
                    r_k <= '0;
                    r_dup <= 1'b0;
                    r_state <= S_OUT;
                    case (r_mode)
                        lrt_pkg::MODE_ADD: begin
                            if (r_hit) begin
                                r_e <= r_hit_idx;
                                if (r_hasgw) begin
                                    r_state <= S_HOPS;
                                end
                            end else if (!r_free) begin
                                r_o_status <= lrt_pkg::ST_TBL_FULL;
                            end else begin
                                r_e <= r_free_idx;
                                r_valid[r_free_idx] <= 1'b1;
                                r_used[r_free_idx] <= '0;
                                r_rr[r_free_idx] <= '0;
                                if (r_hasgw) begin
                                    r_state <= S_HOPS;
                                end
                            end
                        end
                        lrt_pkg::MODE_LOOKUP: begin
                            if (!r_best && !r_dflt) begin
                                r_o_status <= lrt_pkg::ST_NOT_FND;
                            end else begin
                                r_e <= n_sel;
                                r_o_found <= 1'b1;
                                r_o_direct <= m_direct[n_sel];
                                r_o_cost <= m_cost[n_sel];
                                r_o_len <= m_length[n_sel];
                                if (!m_direct[n_sel]) begin
                                    r_state <= S_LRD;
                                end
                            end
                        end
                        lrt_pkg::MODE_DELETE: begin
                            if (r_hit) begin
                                r_valid[r_hit_idx] <= 1'b0;
                            end else begin
                                r_o_status <= lrt_pkg::ST_NOT_FND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_HOPS: begin
                    if (r_k >= sel_used || r_k >= CW'(HOPS_PER_ROUTE)) begin
                        r_state <= S_HRES;
                    end else begin
                        r_state <= S_LOUT;
                    end
                end
                S_LOUT: begin
                    if (r_mode == lrt_pkg::MODE_LOOKUP) begin
                        r_o_nhip <= r_rd_gw;
                        r_o_nhif <= 4'(r_rd_port);
                        r_rr[r_e] <= n_p;
                        r_state <= S_OUT;
                    end else if (r_rd_gw == r_gw && r_rd_port == r_port[PW-1:0]) begin
                        r_dup <= 1'b1;
                        r_o_status <= lrt_pkg::ST_DUP_HOP;
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + CW'(1);
                        r_state <= S_HOPS;
                    end
                end
                S_HRES: begin
                    if (r_k >= CW'(HOPS_PER_ROUTE)) begin
                        r_o_status <= lrt_pkg::ST_HOP_FULL;
                    end else begin
                        r_used[r_e] <= r_k + CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_LRD: begin
                    r_state <= S_LOUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input and output both open");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_status == lrt_pkg::ST_NOT_FND) |-> !r_o_found)
        else $error("miss reported as found");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_direct) |-> (r_o_nhip == 32'd0))
        else $error("direct route with gateway");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < NW'(TABLE_ENTRIES)))
        else $error("scan index out of range");
endmodule
